>>> src/clbp_pkg.sv
// ----------------------------------------------------------------------------
// clbp_pkg
// Shared types, constants and functions for the correlating and local
// branch predictor.
// ----------------------------------------------------------------------------
package clbp_pkg;

    localparam int GLOBAL_TABLE_COUNT_DEF  = 64;
    localparam int TABLE_ENTRIES_DEF       = 256;
    localparam int HISTORY_BITS_DEF        = 6;
    localparam int LOCAL_HISTORY_COUNT_DEF = 16;

    localparam int ADDR_W   = 8;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HISTORY_ENABLE  = 1'b0,
        CFG_COUNTER_TWO_BIT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_rmw_ctl;

    function automatic logic [1:0] sat2_next(input logic [1:0] c, input logic t);
        logic [1:0] n;
        case (c)
            2'd0:    n = t ? 2'd1 : 2'd0;
            2'd1:    n = t ? 2'd3 : 2'd0;
            2'd2:    n = t ? 2'd3 : 2'd0;
            default: n = t ? 2'd3 : 2'd2;
        endcase
        return n;
    endfunction

endpackage

>>> src/clbp_gtable.sv
// ----------------------------------------------------------------------------
// clbp_gtable
// Global counter memory with registered read, write-to-read
// forwarding and a clearing pass after reset.
// ----------------------------------------------------------------------------
module clbp_gtable #(
    parameter int DEPTH = clbp_pkg::GLOBAL_TABLE_COUNT_DEF * clbp_pkg::TABLE_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clbp_pkg::t_rmw_ctl i_ctl,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [1:0]        i_wr_data,
    output logic [1:0]        o_rd_data,
    output logic              o_busy
);

    logic [1:0]    mem [DEPTH];
    logic [1:0]    r_q;
    logic [AW-1:0] r_rd_addr;
    logic          r_fwd_v;
    logic [AW-1:0] r_fwd_addr;
    logic [1:0]    r_fwd_data;
    logic          r_clearing;
    logic [AW-1:0] r_clr_idx;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [1:0]    mem_wdata;

    assign mem_we    = r_clearing || i_ctl.wr_en;
    assign mem_waddr = r_clearing ? r_clr_idx : i_wr_addr;
    assign mem_wdata = r_clearing ? 2'd0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_ctl.rd_en) begin
            r_q       <= mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
        if (i_ctl.rd_en || i_ctl.wr_en) begin
            r_fwd_addr <= i_wr_addr;
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v    <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            if (i_ctl.rd_en || i_ctl.wr_en) begin
                r_fwd_v <= i_ctl.wr_en;
            end
            if (r_clearing) begin
                if (r_clr_idx == AW'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    assign o_rd_data = (r_fwd_v && (r_fwd_addr == r_rd_addr)) ? r_fwd_data : r_q;
    assign o_busy    = r_clearing;

endmodule

>>> src/clbp_ltable.sv
// ----------------------------------------------------------------------------
// clbp_ltable
// Local counter memory with registered read, write-to-read
// forwarding and per-entry valid bits that make unwritten entries read zero.
// ----------------------------------------------------------------------------
module clbp_ltable #(
    parameter int AW    = clbp_pkg::HISTORY_BITS_DEF,
    parameter int DEPTH = 2 ** AW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clbp_pkg::t_rmw_ctl i_ctl,
    input  logic [AW-1:0]      i_rd_addr,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [1:0]         i_wr_data,
    output logic [1:0]         o_rd_data
);

    logic [1:0]    mem [DEPTH];
    logic          r_valid [DEPTH];
    logic [1:0]    r_q;
    logic          r_qv;
    logic [AW-1:0] r_rd_addr;
    logic          r_fwd_v;
    logic [AW-1:0] r_fwd_addr;
    logic [1:0]    r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_q       <= mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
        if (i_ctl.rd_en || i_ctl.wr_en) begin
            r_fwd_addr <= i_wr_addr;
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
            r_qv    <= 1'b0;
            for (int k = 0; k < DEPTH; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            if (i_ctl.rd_en || i_ctl.wr_en) begin
                r_fwd_v <= i_ctl.wr_en;
            end
            if (i_ctl.rd_en) begin
                r_qv <= r_valid[i_rd_addr];
            end
            if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    always_comb begin
        if (r_fwd_v && (r_fwd_addr == r_rd_addr)) begin
            o_rd_data = r_fwd_data;
        end else if (r_qv) begin
            o_rd_data = r_q;
        end else begin
            o_rd_data = 2'd0;
        end
    end

endmodule

>>> src/correlating_and_local_branch_predictor_core.sv
// ----------------------------------------------------------------------------
// correlating_and_local_branch_predictor_core
// Correlating global predictor beside a per-address local predictor. Each
// resolved branch yields both predictions and miss flags, then trains both.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   branch_address, taken
// m_axis    out        m_axis_tvalid/m_axis_tready   predictions and misses
// cfg       in         i_cfg_valid/o_cfg_ready       register index and data
//
// One branch is accepted per cycle while the output is not stalled and the
// global memory is not being cleared; its result is registered by the read
// of the counter memories and then by the output register.
// After reset the global counter memory is cleared one entry per cycle over
// all GLOBAL_TABLE_COUNT * TABLE_ENTRIES entries, and s_axis_tready stays low.
// A stalled output register holds one result and the read stage holds one
// more branch before s_axis_tready drops.
// ----------------------------------------------------------------------------
module correlating_and_local_branch_predictor_core #(
    parameter int GLOBAL_TABLE_COUNT  = clbp_pkg::GLOBAL_TABLE_COUNT_DEF,
    parameter int TABLE_ENTRIES       = clbp_pkg::TABLE_ENTRIES_DEF,
    parameter int HISTORY_BITS        = clbp_pkg::HISTORY_BITS_DEF,
    parameter int LOCAL_HISTORY_COUNT = clbp_pkg::LOCAL_HISTORY_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: branch_address[7:0], taken[8].
    input  logic [clbp_pkg::S_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0: global_predict_taken, global_miss,
    // local_predict_taken, local_miss.
    output logic [clbp_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [clbp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                           i_cfg_data
);

    localparam int GDEPTH = GLOBAL_TABLE_COUNT * TABLE_ENTRIES;
    localparam int GAW    = $clog2(GDEPTH);
    localparam int TAB_W  = $clog2(GLOBAL_TABLE_COUNT);
    localparam int ENT_W  = $clog2(TABLE_ENTRIES);
    localparam int LHI_W  = $clog2(LOCAL_HISTORY_COUNT);
    localparam int HB     = HISTORY_BITS;
    localparam int ADDR_N = 2 ** clbp_pkg::ADDR_W;

    logic [TAB_W-1:0] tab_lut [2 ** HB];
    logic [ENT_W-1:0] ent_lut [ADDR_N];
    logic [LHI_W-1:0] lhi_lut [ADDR_N];

    for (genvar g = 0; g < 2 ** HB; g++) begin : g_tab
        localparam int TAB_VAL = g % GLOBAL_TABLE_COUNT;
        assign tab_lut[g] = TAB_W'(TAB_VAL);
    end

    for (genvar a = 0; a < ADDR_N; a++) begin : g_addr
        localparam int ENT_VAL = a % TABLE_ENTRIES;
        localparam int LHI_VAL = a % LOCAL_HISTORY_COUNT;
        assign ent_lut[a] = ENT_W'(ENT_VAL);
        assign lhi_lut[a] = LHI_W'(LHI_VAL);
    end

    function automatic logic [HB-1:0] shift_in(input logic [HB-1:0] h, input logic t);
        return (h >> 1) | (HB'(t) << (HB - 1));
    endfunction

    logic                        r_hist_en;
    logic                        r_two_bit;
    logic [HB-1:0]               r_ghist;
    logic [HB-1:0]               r_lhist [LOCAL_HISTORY_COUNT];
    logic                        r_s1_v;
    logic                        r_s1_taken;
    logic [GAW-1:0]              r_s1_gidx;
    logic [HB-1:0]               r_s1_lidx;
    logic                        r_out_v;
    logic [3:0]                  r_out;

    logic [clbp_pkg::ADDR_W-1:0] in_addr;
    logic                        in_taken;
    logic                        accept;
    logic                        adv1;
    logic                        gbusy;
    logic [TAB_W-1:0]            tab;
    logic [GAW-1:0]              gidx;
    logic [LHI_W-1:0]            lhi;
    logic [HB-1:0]               lh;
    logic [1:0]                  gc;
    logic [1:0]                  lc;
    logic                        gp;
    logic                        lp;
    logic [1:0]                  gc_next;
    logic                        g_wr;
    clbp_pkg::t_rmw_ctl          gctl;
    clbp_pkg::t_rmw_ctl          lctl;

    assign in_addr  = s_axis_tdata[clbp_pkg::ADDR_W-1:0];
    assign in_taken = s_axis_tdata[clbp_pkg::ADDR_W];

    assign adv1          = r_s1_v && (!r_out_v || m_axis_tready);
    assign s_axis_tready = (!r_s1_v || adv1) && !gbusy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign tab  = r_hist_en ? tab_lut[r_ghist] : '0;
    assign gidx = GAW'(tab) * GAW'(TABLE_ENTRIES) + GAW'(ent_lut[in_addr]);
    assign lhi  = lhi_lut[in_addr];
    assign lh   = r_lhist[lhi];

    always_comb begin
        if (r_two_bit) begin
            gp      = gc[1];
            gc_next = clbp_pkg::sat2_next(gc, r_s1_taken);
            g_wr    = adv1;
        end else begin
            gp      = (gc != 2'd0);
            gc_next = {1'b0, r_s1_taken};
            g_wr    = adv1 && (gp != r_s1_taken);
        end
    end

    assign lp = lc[1];

    assign gctl.rd_en = accept;
    assign gctl.wr_en = g_wr;
    assign lctl.rd_en = accept;
    assign lctl.wr_en = adv1;

    clbp_gtable #(
        .DEPTH (GDEPTH),
        .AW    (GAW)
    ) u_gtable (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (gctl),
        .i_rd_addr (gidx),
        .i_wr_addr (r_s1_gidx),
        .i_wr_data (gc_next),
        .o_rd_data (gc),
        .o_busy    (gbusy)
    );

    clbp_ltable #(
        .AW    (HB),
        .DEPTH (2 ** HB)
    ) u_ltable (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (lctl),
        .i_rd_addr (lh),
        .i_wr_addr (r_s1_lidx),
        .i_wr_data (clbp_pkg::sat2_next(lc, r_s1_taken)),
        .o_rd_data (lc)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_taken <= in_taken;
            r_s1_gidx  <= gidx;
            r_s1_lidx  <= lh;
        end
        if (adv1) begin
            r_out <= {lp != r_s1_taken, lp, gp != r_s1_taken, gp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_en <= 1'b1;
            r_two_bit <= 1'b1;
            r_ghist   <= '0;
            r_s1_v    <= 1'b0;
            r_out_v   <= 1'b0;
            for (int k = 0; k < LOCAL_HISTORY_COUNT; k++) begin
                r_lhist[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    clbp_pkg::CFG_HISTORY_ENABLE:  r_hist_en <= i_cfg_data;
                    clbp_pkg::CFG_COUNTER_TWO_BIT: r_two_bit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                if (r_hist_en) begin
                    r_ghist <= shift_in(r_ghist, in_taken);
                end
                r_lhist[lhi] <= shift_in(lh, in_taken);
            end
            if (accept || adv1) begin
                r_s1_v <= accept;
            end
            if (adv1) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {(clbp_pkg::M_DATA_W - 4)'(0), r_out};

endmodule
